// File: rtl/core/lprt_pkg.sv
// Package for the route table: codes, item types and mask helpers.
`timescale 1ns / 1ps
package lprt_pkg;

  localparam int ROUTE_ENTRIES_DEF = 16;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] FAM_V4 = 2'd1;
  localparam logic [1:0] FAM_V6 = 2'd2;

  localparam logic [7:0] IFACE_INVALID = 8'd255;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam int IN_BITS  = 2 + 2 + 8 + 6 * 64 + 1 + 32;
  localparam int IN_BYTES = (IN_BITS + 7) / 8;
  localparam int OUT_BITS = 2 + 4 + 8 + 32 + 64 + 64;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

  // Request after classification, with bytes beyond the family cleared.
  typedef struct packed {
    logic [1:0]  op;
    logic        bad;
    logic [1:0]  family;
    logic [7:0]  iface;
    logic [63:0] dest_hi;
    logic [63:0] dest_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic [63:0] gw_hi;
    logic [63:0] gw_lo;
    logic [31:0] metric;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [7:0]  iface;
    logic [31:0] metric;
    logic [63:0] gw_hi;
    logic [63:0] gw_lo;
  } res_t;

  function automatic logic [3:0] lead_ones8(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n = 4'd0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      run = run & b[i];
      n = n + {3'd0, run};
    end
    return n;
  endfunction

  // Sum of leading ones over the eight bytes of a word.
  function automatic logic [6:0] lead_ones64(input logic [63:0] w);
    logic [6:0] t;
    t = 7'd0;
    for (int j = 0; j < 8; j++) begin
      t = t + {3'd0, lead_ones8(w[63 - 8 * j -: 8])};
    end
    return t;
  endfunction

endpackage

// File: rtl/core/longest_prefix_route_table_top.sv
// Top level of the longest-prefix-match route table.
//
//  Channel  Direction  Contents
//  s_axis   in         one request: op, family, iface, addresses, gateway, metric
//  m_axis   out        one result: status, slot, iface, metric, gateway
//
// The back end handles a request in steps: it takes it from the queue, passes
// each table entry in turn through the single compare unit, writes back and
// registers the result, and offers the result until it is taken. A request
// flagged bad skips the scan. Reset clears all valid bits at once. A two-entry
// queue lets requests in while a result waits.
`timescale 1ns / 1ps
module longest_prefix_route_table_top
  import lprt_pkg::*;
#(
  parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // op, family, iface, dest_hi, dest_lo, mask_hi, mask_lo, gateway_hi,
  // gateway_lo, has_gateway, metric (lowest bits first)
  input  logic [IN_BYTES*8-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status, slot, out_iface, out_metric, out_gateway_hi, out_gateway_lo
  output logic [OUT_BYTES*8-1:0] m_axis_tdata
);

  logic q_valid, q_ready;
  req_t q_req;
  res_t res;

  lprt_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  lprt_back #(.ROUTE_ENTRIES(ROUTE_ENTRIES)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {(OUT_BYTES*8-OUT_BITS)'(0), res.gw_lo, res.gw_hi,
                         res.metric, res.iface, res.slot, res.status};

endmodule

// File: rtl/core/lprt_front.sv
// Front end: accepts requests, checks arguments and masks unused bytes.
`timescale 1ns / 1ps
module lprt_front
  import lprt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [IN_BYTES*8-1:0] in_data,
  output logic                  q_valid,
  input  logic                  q_ready,
  output req_t                  q_req
);

  logic [1:0]  op, fam;
  logic [7:0]  iface;
  logic [63:0] dh, dl, mh, ml, gh, gl, kh, kl;
  logic        has_gw;
  logic [31:0] metric;
  req_t        req;

  assign op     = in_data[1:0];
  assign fam    = in_data[3:2];
  assign iface  = in_data[11:4];
  assign dh     = in_data[75:12];
  assign dl     = in_data[139:76];
  assign mh     = in_data[203:140];
  assign ml     = in_data[267:204];
  assign gh     = in_data[331:268];
  assign gl     = in_data[395:332];
  assign has_gw = in_data[396];
  assign metric = in_data[428:397];

  always_comb begin
    kh = (fam == FAM_V4) ? 64'hFFFF_FFFF_0000_0000 : '1;
    kl = (fam == FAM_V4) ? 64'd0 : '1;
    req.op      = op;
    req.family  = fam;
    req.iface   = iface;
    req.bad     = (op == 2'd3) || (fam != FAM_V4 && fam != FAM_V6) ||
                  (op == OP_ADD && iface == IFACE_INVALID);
    req.dest_hi = dh & kh;
    req.dest_lo = dl & kl;
    req.mask_hi = mh & kh;
    req.mask_lo = ml & kl;
    req.gw_hi   = has_gw ? (gh & kh) : 64'd0;
    req.gw_lo   = has_gw ? (gl & kl) : 64'd0;
    req.metric  = metric;
  end

  // Two-entry queue so the front can take a request while the back scans.
  req_t q_mem [2];
  logic q_wp, q_rp;
  logic [1:0] q_cnt;

  assign in_ready = (q_cnt != 2'd2);
  assign q_valid  = (q_cnt != 2'd0);
  assign q_req    = q_mem[q_rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_mem[q_wp] <= req;
    end
    if (rst) begin
      q_wp <= 1'b0;
      q_rp <= 1'b0;
      q_cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) q_wp <= ~q_wp;
      if (q_valid && q_ready) q_rp <= ~q_rp;
      q_cnt <= q_cnt + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
    end
  end

endmodule

// File: rtl/core/lprt_back.sv
// Back end: table storage and the sequential scan that executes each request.
`timescale 1ns / 1ps
module lprt_back
  import lprt_pkg::*;
#(
  parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  req_t q_req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CW = $clog2(ROUTE_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  req_t       cur;
  logic [CW-1:0] idx;

  logic [ROUTE_ENTRIES-1:0] valid;
  logic [1:0]  t_fam   [ROUTE_ENTRIES];
  logic [7:0]  t_iface [ROUTE_ENTRIES];
  logic [31:0] t_met   [ROUTE_ENTRIES];
  logic [63:0] t_dh [ROUTE_ENTRIES];
  logic [63:0] t_dl [ROUTE_ENTRIES];
  logic [63:0] t_mh [ROUTE_ENTRIES];
  logic [63:0] t_ml [ROUTE_ENTRIES];
  logic [63:0] t_gh [ROUTE_ENTRIES];
  logic [63:0] t_gl [ROUTE_ENTRIES];

  logic          exact_found, free_found, best_found;
  logic [IW-1:0] exact_idx, free_idx, best_idx;
  logic [7:0]    best_len;
  logic [31:0]   best_met;

  logic [IW-1:0] ci;
  logic          e_exact, e_hit;
  logic [7:0]    e_len;
  res_t          res_next;

  assign ci = idx[IW-1:0];

  // One entry is compared per cycle.
  always_comb begin
    e_exact = valid[ci] && t_fam[ci] == cur.family &&
              t_dh[ci] == cur.dest_hi && t_dl[ci] == cur.dest_lo &&
              t_mh[ci] == cur.mask_hi && t_ml[ci] == cur.mask_lo;
    e_hit = valid[ci] && t_fam[ci] == cur.family &&
            ((cur.dest_hi ^ t_dh[ci]) & t_mh[ci]) == 64'd0 &&
            ((cur.dest_lo ^ t_dl[ci]) & t_ml[ci]) == 64'd0;
    e_len = {1'b0, lead_ones64(t_mh[ci])} + {1'b0, lead_ones64(t_ml[ci])};
  end

  // Result of a finished scan.
  always_comb begin
    res_next = '0;
    case (cur.op)
      OP_ADD: begin
        if (exact_found) begin
          res_next.status = ST_OK;
          res_next.slot = 4'(exact_idx);
        end else if (free_found) begin
          res_next.status = ST_OK;
          res_next.slot = 4'(free_idx);
        end else begin
          res_next.status = ST_NO_SPACE;
        end
      end
      OP_REMOVE: begin
        if (exact_found) begin
          res_next.status = ST_OK;
          res_next.slot = 4'(exact_idx);
        end else begin
          res_next.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (best_found) begin
          res_next.status = ST_OK;
          res_next.slot = 4'(best_idx);
          res_next.iface = t_iface[best_idx];
          res_next.metric = t_met[best_idx];
          res_next.gw_hi = t_gh[best_idx];
          res_next.gw_lo = t_gl[best_idx];
        end else begin
          res_next.status = ST_NOT_FOUND;
        end
      end
    endcase
  end

  assign q_ready   = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_req;
            idx <= '0;
            exact_found <= 1'b0;
            free_found <= 1'b0;
            best_found <= 1'b0;
            if (q_req.bad) begin
              res <= '{status: ST_INVALID, default: '0};
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx != CW'(ROUTE_ENTRIES)) begin
            if (e_exact && !exact_found) begin
              exact_found <= 1'b1;
              exact_idx <= ci;
            end
            if (!valid[ci] && !free_found) begin
              free_found <= 1'b1;
              free_idx <= ci;
            end
            if (e_hit && (!best_found || e_len > best_len ||
                (e_len == best_len && t_met[ci] < best_met))) begin
              best_found <= 1'b1;
              best_idx <= ci;
              best_len <= e_len;
              best_met <= t_met[ci];
            end
            idx <= idx + 1'b1;
          end else begin
            res <= res_next;
            state <= S_DONE;
            case (cur.op)
              OP_ADD: begin
                if (exact_found || free_found) begin
                  if (!exact_found) begin
                    valid[free_idx] <= 1'b1;
                    t_fam[free_idx] <= cur.family;
                    t_dh[free_idx] <= cur.dest_hi;
                    t_dl[free_idx] <= cur.dest_lo;
                    t_mh[free_idx] <= cur.mask_hi;
                    t_ml[free_idx] <= cur.mask_lo;
                    t_iface[free_idx] <= cur.iface;
                    t_met[free_idx] <= cur.metric;
                    t_gh[free_idx] <= cur.gw_hi;
                    t_gl[free_idx] <= cur.gw_lo;
                  end else begin
                    t_iface[exact_idx] <= cur.iface;
                    t_met[exact_idx] <= cur.metric;
                    t_gh[exact_idx] <= cur.gw_hi;
                    t_gl[exact_idx] <= cur.gw_lo;
                  end
                end
              end
              OP_REMOVE: begin
                if (exact_found) begin
                  valid[exact_idx] <= 1'b0;
                  t_iface[exact_idx] <= IFACE_INVALID;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DONE: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
